/* rtl/mse_pkg.sv */
// ----------------------------------------------------------------------------
// mse_pkg
// shared types, sizes and instruction codes of the mips subset executor
// ----------------------------------------------------------------------------
package mse_pkg;

	// data memory geometry (power of two bytes, four byte lanes)
	localparam int MEM_BYTES = 4096;
	localparam int ADDR_W    = $clog2(MEM_BYTES);
	localparam int MEM_ROWS  = MEM_BYTES / 4;
	localparam int ROW_W     = $clog2(MEM_ROWS);

	localparam logic [31:0] CODE_START = 32'h0000_0000;

	// register file
	localparam int NUM_REGS = 32;
	localparam int REG_AW   = $clog2(NUM_REGS);

	// transaction field widths
	localparam int MODE_W  = 2;
	localparam int WORD_W  = 32;
	localparam int MADDR_W = 12;

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// modes
	localparam logic [MODE_W-1:0] MODE_EXEC   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEM_WR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MEM_RD = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// decoded instruction codes (funct for opcode zero, else opcode)
	localparam logic [5:0] CODE_BGE  = 6'h01;
	localparam logic [5:0] CODE_J    = 6'h02;
	localparam logic [5:0] CODE_ADDI = 6'h08;
	localparam logic [5:0] CODE_ADD  = 6'h20;
	localparam logic [5:0] CODE_LW   = 6'h23;
	localparam logic [5:0] CODE_SW   = 6'h2B;
	localparam logic [5:0] CODE_LA   = 6'h2F;
	localparam logic [5:0] OPC_SPECIAL = 6'h00;

	typedef enum logic [3:0] {
		K_NONE,
		K_HALT,
		K_BAD,
		K_LA,
		K_LW,
		K_SW,
		K_J,
		K_BGE,
		K_ADDI,
		K_ADD,
		K_MWR,
		K_MRD
	} op_kind_t;

	typedef struct packed {
		op_kind_t            kind;
		logic [REG_AW-1:0]   rs;
		logic [REG_AW-1:0]   rt;
		logic [REG_AW-1:0]   rd;
		logic [15:0]         imm;
		logic [25:0]         target;
		logic [MADDR_W-1:0]  mem_address;
		logic [WORD_W-1:0]   mem_data;
	} cmd_entry_t;

	typedef enum logic [1:0] {
		ST_READ,
		ST_EXEC,
		ST_LOAD
	} back_state_t;

endpackage

/* rtl/mse_cmd_if.sv */
// ----------------------------------------------------------------------------
// mse_cmd_if
// command channel: one instruction or data memory access per transaction
// ----------------------------------------------------------------------------
interface mse_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [mse_pkg::MODE_W-1:0]  mode;
	logic [mse_pkg::WORD_W-1:0]  instruction;
	logic [mse_pkg::MADDR_W-1:0] mem_address;
	logic [mse_pkg::WORD_W-1:0]  mem_data;

	modport source (output valid, mode, instruction, mem_address, mem_data, input ready);
	modport sink   (input valid, mode, instruction, mem_address, mem_data, output ready);
endinterface

/* rtl/mse_res_if.sv */
// ----------------------------------------------------------------------------
// mse_res_if
// result channel: pc, status flags and read data per transaction
// ----------------------------------------------------------------------------
interface mse_res_if;
	logic                       valid;
	logic                       ready;
	logic [mse_pkg::WORD_W-1:0] next_pc;
	logic                       halted;
	logic                       bad_instruction;
	logic [mse_pkg::WORD_W-1:0] read_data;

	modport source (output valid, next_pc, halted, bad_instruction, read_data, input ready);
	modport sink   (input valid, next_pc, halted, bad_instruction, read_data, output ready);
endinterface

/* rtl/mse_ram.sv */
// ----------------------------------------------------------------------------
// mse_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mse_front.sv */
// ----------------------------------------------------------------------------
// mse_front
// accepts command transactions, classifies them and queues them for the back
// ----------------------------------------------------------------------------
module mse_front (
	input  logic                clk,
	input  logic                arst_n,
	mse_cmd_if.sink             cmd,
	output mse_pkg::cmd_entry_t head,
	output logic                head_valid,
	input  logic                pop
);

	mse_pkg::cmd_entry_t             entries_q [mse_pkg::QDEPTH];
	logic [mse_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mse_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mse_pkg::QCNT_W-1:0]      count_q;
	mse_pkg::cmd_entry_t             dec;
	logic [5:0]                      code;
	logic                            push;
	logic                            do_pop;

	// classify the incoming transaction
	always_comb begin
		code = (cmd.instruction[31:26] == mse_pkg::OPC_SPECIAL) ?
			cmd.instruction[5:0] : cmd.instruction[31:26];
		dec.rs          = cmd.instruction[25:21];
		dec.rt          = cmd.instruction[20:16];
		dec.rd          = cmd.instruction[15:11];
		dec.imm         = cmd.instruction[15:0];
		dec.target      = cmd.instruction[25:0];
		dec.mem_address = cmd.mem_address;
		dec.mem_data    = cmd.mem_data;
		dec.kind        = mse_pkg::K_NONE;
		unique case (cmd.mode)
			mse_pkg::MODE_MEM_WR: dec.kind = mse_pkg::K_MWR;
			mse_pkg::MODE_MEM_RD: dec.kind = mse_pkg::K_MRD;
			mse_pkg::MODE_UNUSED: dec.kind = mse_pkg::K_NONE;
			mse_pkg::MODE_EXEC: begin
				if (cmd.instruction == '0) begin
					dec.kind = mse_pkg::K_HALT;
				end else begin
					unique case (code)
						mse_pkg::CODE_LA:   dec.kind = mse_pkg::K_LA;
						mse_pkg::CODE_LW:   dec.kind = mse_pkg::K_LW;
						mse_pkg::CODE_SW:   dec.kind = mse_pkg::K_SW;
						mse_pkg::CODE_J:    dec.kind = mse_pkg::K_J;
						mse_pkg::CODE_BGE:  dec.kind = mse_pkg::K_BGE;
						mse_pkg::CODE_ADDI: dec.kind = mse_pkg::K_ADDI;
						mse_pkg::CODE_ADD:  dec.kind = mse_pkg::K_ADD;
						default:            dec.kind = mse_pkg::K_BAD;
					endcase
				end
			end
		endcase
	end

	assign cmd.ready  = (count_q != mse_pkg::QCNT_W'(mse_pkg::QDEPTH));
	assign push       = cmd.valid && cmd.ready;
	assign head_valid = (count_q != '0);
	assign do_pop     = pop && head_valid;
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/mse_back.sv */
// ----------------------------------------------------------------------------
// mse_back
// executes queued commands against register file, pc and data memory
// ----------------------------------------------------------------------------
module mse_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mse_pkg::cmd_entry_t head,
	input  logic                head_valid,
	output logic                pop,
	mse_res_if.source           res
);

	mse_pkg::back_state_t           state_q, state_d;
	mse_pkg::cmd_entry_t            cur_q;
	logic [31:0]                    pc_q, pc_d;
	logic [mse_pkg::NUM_REGS-1:0]   rvalid_q;
	logic                           rs_vld_q, rt_vld_q;
	logic                           rs_byp_q, rt_byp_q;
	logic [31:0]                    byp_data_q;
	logic [1:0]                     load_off_q;

	logic                           out_valid_q;
	logic [31:0]                    out_pc_q;
	logic                           out_halt_q;
	logic                           out_bad_q;
	logic [31:0]                    out_rdata_q;

	logic                           issue;
	logic                           res_load;
	logic [31:0]                    res_pc;
	logic                           res_halt;
	logic                           res_bad;
	logic [31:0]                    res_rdata;
	logic                           out_free;

	logic                           rf_we;
	logic [mse_pkg::REG_AW-1:0]     rf_waddr;
	logic [31:0]                    rf_wdata;
	logic [31:0]                    rf_a_rdata, rf_b_rdata;
	logic [31:0]                    rs_val, rt_val;
	logic [31:0]                    imm_sx;

	logic                           mem_we, mem_re;
	logic [31:0]                    eff_addr;
	logic [mse_pkg::ADDR_W-1:0]     base;
	logic [1:0]                     off;
	logic [mse_pkg::ROW_W-1:0]      row;
	logic [31:0]                    st_data;
	logic [mse_pkg::ROW_W-1:0]      lane_addr  [4];
	logic [7:0]                     lane_wdata [4];
	logic [7:0]                     lane_rdata [4];
	logic [31:0]                    ld_word;

	assign out_free = !out_valid_q || res.ready;

	// operands: bypass of a write seen at issue, else ram data, unwritten regs read zero
	assign rs_val = rs_byp_q ? byp_data_q : (rs_vld_q ? rf_a_rdata : '0);
	assign rt_val = rt_byp_q ? byp_data_q : (rt_vld_q ? rf_b_rdata : '0);
	assign imm_sx = {{16{cur_q.imm[15]}}, cur_q.imm};

	// byte address and lane split
	always_comb begin
		if (cur_q.kind == mse_pkg::K_MWR || cur_q.kind == mse_pkg::K_MRD) begin
			eff_addr = {{(32 - mse_pkg::MADDR_W){1'b0}}, cur_q.mem_address};
			st_data  = cur_q.mem_data;
		end else begin
			eff_addr = rs_val + imm_sx;
			st_data  = rt_val;
		end
		base = eff_addr[mse_pkg::ADDR_W-1:0];
		off  = base[1:0];
		row  = base[mse_pkg::ADDR_W-1:2];
		for (int l = 0; l < 4; l++) begin
			lane_addr[l]  = row + ((2'(l) < off) ? mse_pkg::ROW_W'(1) : '0);
			lane_wdata[l] = st_data[{2'(2'(l) - off), 3'b000} +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			ld_word[8*i +: 8] = lane_rdata[2'(load_off_q + 2'(i))];
		end
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		pc_d      = pc_q;
		pop       = 1'b0;
		issue     = 1'b0;
		rf_we     = 1'b0;
		rf_waddr  = cur_q.rt;
		rf_wdata  = ld_word;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_load  = 1'b0;
		res_pc    = pc_q;
		res_halt  = 1'b0;
		res_bad   = 1'b0;
		res_rdata = '0;
		unique case (state_q)
			mse_pkg::ST_READ: begin
				if (head_valid) begin
					pop     = 1'b1;
					issue   = 1'b1;
					state_d = mse_pkg::ST_EXEC;
				end
			end
			mse_pkg::ST_EXEC: begin
				if (cur_q.kind == mse_pkg::K_LW || cur_q.kind == mse_pkg::K_MRD) begin
					mem_re  = 1'b1;
					state_d = mse_pkg::ST_LOAD;
					if (cur_q.kind == mse_pkg::K_LW) begin
						pc_d = pc_q + 32'd4;
					end
				end else if (out_free) begin
					res_load = 1'b1;
					state_d  = mse_pkg::ST_READ;
					unique case (cur_q.kind)
						mse_pkg::K_LA: begin
							rf_we    = 1'b1;
							rf_wdata = {16'h0000, cur_q.imm};
							pc_d     = pc_q + 32'd4;
						end
						mse_pkg::K_SW: begin
							mem_we = 1'b1;
							pc_d   = pc_q + 32'd4;
						end
						mse_pkg::K_J: pc_d = {4'h0, cur_q.target, 2'b00};
						mse_pkg::K_BGE: begin
							if (rs_val >= rt_val) begin
								pc_d = pc_q + 32'd4 + {imm_sx[29:0], 2'b00};
							end else begin
								pc_d = pc_q + 32'd4;
							end
						end
						mse_pkg::K_ADDI: begin
							rf_we    = 1'b1;
							rf_wdata = rs_val + imm_sx;
							pc_d     = pc_q + 32'd4;
						end
						mse_pkg::K_ADD: begin
							rf_we    = 1'b1;
							rf_waddr = cur_q.rd;
							rf_wdata = rs_val + rt_val;
							pc_d     = pc_q + 32'd4;
						end
						mse_pkg::K_MWR:  mem_we = 1'b1;
						mse_pkg::K_HALT: res_halt = 1'b1;
						mse_pkg::K_BAD:  res_bad = 1'b1;
						default: ;
					endcase
					res_pc = pc_d;
				end
			end
			mse_pkg::ST_LOAD: begin
				if (out_free) begin
					res_load = 1'b1;
					if (cur_q.kind == mse_pkg::K_LW) begin
						rf_we = 1'b1;
					end else begin
						res_rdata = ld_word;
					end
					// overlap write-back with the next register read
					if (head_valid) begin
						pop     = 1'b1;
						issue   = 1'b1;
						state_d = mse_pkg::ST_EXEC;
					end else begin
						state_d = mse_pkg::ST_READ;
					end
				end
			end
			default: state_d = mse_pkg::ST_READ;
		endcase
	end

	// register file, one copy per read port
	mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (issue),
		.raddr (head.rs),
		.rdata (rf_a_rdata)
	);

	mse_ram #(.WIDTH(32), .DEPTH(mse_pkg::NUM_REGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (issue),
		.raddr (head.rt),
		.rdata (rf_b_rdata)
	);

	// data memory, four byte lanes
	for (genvar g = 0; g < 4; g++) begin : g_lane
		mse_ram #(.WIDTH(8), .DEPTH(mse_pkg::MEM_ROWS)) u_lane (
			.clk   (clk),
			.we    (mem_we),
			.waddr (lane_addr[g]),
			.wdata (lane_wdata[g]),
			.re    (mem_re),
			.raddr (lane_addr[g]),
			.rdata (lane_rdata[g])
		);
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q      <= head;
			rs_byp_q   <= rf_we && (rf_waddr == head.rs);
			rt_byp_q   <= rf_we && (rf_waddr == head.rt);
			byp_data_q <= rf_wdata;
			rs_vld_q   <= rvalid_q[head.rs];
			rt_vld_q   <= rvalid_q[head.rt];
		end
		if (mem_re) begin
			load_off_q <= off;
		end
		if (res_load) begin
			out_pc_q    <= res_pc;
			out_halt_q  <= res_halt;
			out_bad_q   <= res_bad;
			out_rdata_q <= res_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mse_pkg::ST_READ;
			pc_q        <= mse_pkg::CODE_START;
			rvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			if (rf_we) begin
				rvalid_q[rf_waddr] <= 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid           = out_valid_q;
	assign res.next_pc         = out_pc_q;
	assign res.halted          = out_halt_q;
	assign res.bad_instruction = out_bad_q;
	assign res.read_data       = out_rdata_q;

endmodule

/* rtl/mips_subset_execute.sv */
// ----------------------------------------------------------------------------
// mips_subset_execute
// mips32 subset executor: one instruction or data word access per transaction
// ----------------------------------------------------------------------------
// Each command transaction either executes one fetched instruction (la, lw,
// sw, j, bge, addi, add; all-zero word halts, unknown codes flag
// bad_instruction) or preloads / reads one little-endian data word, and
// returns exactly one result transaction with the pc after it. A front end
// decodes commands into a two-entry queue; the back end handles each
// command as a registered register file read followed by an execute step
// that issues the data memory access. Loads finish their write-back in a
// further step that overlaps the next command's register read, so the
// sustained rate is the same for every mix while results are taken. The
// register file starts at zero through per-register valid bits, so there
// is no clearing pass after reset; data memory is undefined until written.
// A registered result stage lets the block keep accepting commands while a
// result waits to be taken.
// ----------------------------------------------------------------------------
module mips_subset_execute (
	input  logic      clk,
	input  logic      arst_n,
	mse_cmd_if.sink   cmd,
	mse_res_if.source res
);

	// decoded command at the head of the queue
	mse_pkg::cmd_entry_t head;
	logic                head_valid;
	logic                pop;

	// front end: handshake, decode and queue
	mse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back end: register file, pc, data memory and result register
	mse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res        (res)
	);

endmodule
